// ----- hw/rtl/mktd_pkg.sv -----
// ----------------------------------------------------------------------------
// mktd_pkg
// Shared types and constants for the morse key timing decoder.
// ----------------------------------------------------------------------------
package mktd_pkg;

    localparam int PATTERN_BITS = 5;
    localparam int UNIT_W       = 12;
    localparam int TICK_W       = 16;
    localparam int COUNT_W      = 3;
    localparam int CODE_W       = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [UNIT_W-1:0]  CAL_FLOOR = UNIT_W'(25);
    localparam logic [UNIT_W-1:0]  UNIT_MAX  = UNIT_W'(4095);
    localparam logic [TICK_W-1:0]  TICK_MAX  = TICK_W'(65535);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] PATTERN_SLOTS = COUNT_W'(PATTERN_BITS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_UNIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CAL  = 1'b1;

    // result kinds
    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_LETTER  = 1'b1;

    typedef struct packed {
        logic key_down;
        logic clear_entry;
    } t_in_beat;

    typedef struct packed {
        logic              result_kind;
        logic              element_is_dash;
        logic [CODE_W-1:0] letter_code;
        logic              pattern_overflow;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_beat;

endpackage

// ----- hw/rtl/mktd_in_stage.sv -----
// ----------------------------------------------------------------------------
// mktd_in_stage
// Input register: holds one key sample until the decode step takes it.
// ----------------------------------------------------------------------------
module mktd_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  mktd_pkg::t_in_beat i_beat,
    input  logic               i_advance,
    output logic               o_valid,
    output mktd_pkg::t_in_beat o_beat
);
    import mktd_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_beat r_beat;
    logic     accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- hw/rtl/mktd_decode.sv -----
// ----------------------------------------------------------------------------
// mktd_decode
// Mark timing, element shift-in and letter timeout for one key sample.
// ----------------------------------------------------------------------------
module mktd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mktd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mktd_pkg::UNIT_W-1:0]   i_cfg_data,
    input  logic                          i_fire,
    input  mktd_pkg::t_in_beat            i_beat,
    output mktd_pkg::t_result_beat        o_result
);
    import mktd_pkg::*;

    logic [UNIT_W-1:0]       r_dot_unit;
    logic                    r_auto_cal;
    logic                    r_key_was_down;
    logic                    r_started;
    logic [TICK_W-1:0]       r_tick;
    logic [PATTERN_BITS-1:0] r_pattern;
    logic [COUNT_W-1:0]      r_count;
    logic                    r_ovf;
    logic [UNIT_W-1:0]       r_learned;

    logic                    n_key_was_down;
    logic                    n_started;
    logic [TICK_W-1:0]       n_tick;
    logic [PATTERN_BITS-1:0] n_pattern;
    logic [COUNT_W-1:0]      n_count;
    logic                    n_ovf;
    logic [UNIT_W-1:0]       n_learned;

    logic [UNIT_W-1:0]  unit;
    logic [UNIT_W+1:0]  dash_lim;
    logic [UNIT_W+2:0]  gap_lim;
    logic               press;
    logic               release_key;
    logic               calibrating;
    logic               timeout;
    logic               dash;
    logic [UNIT_W-1:0]  cal_unit;
    logic [TICK_W-1:0]  tick_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_unit <= UNIT_W'(35);
            r_auto_cal <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DOT_UNIT: r_dot_unit <= i_cfg_data;
                CFG_AUTO_CAL: r_auto_cal <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign unit     = (r_auto_cal && r_learned != '0) ? r_learned : r_dot_unit;
    // 3x the unit as shift-and-add, 7x the unit as shift-and-subtract
    assign dash_lim = {1'b0, unit, 1'b0} + {2'b00, unit};
    assign gap_lim  = {unit, 3'b000} - {3'b000, unit};

    assign press       = i_beat.key_down && !r_key_was_down;
    assign release_key = !i_beat.key_down && r_key_was_down;
    assign calibrating = r_auto_cal && (r_learned == '0);
    assign timeout     = !press && !release_key && ({1'b0, r_tick} > {2'b00, gap_lim})
                         && (r_count != '0);

    always_comb begin
        if (r_tick < TICK_W'(CAL_FLOOR)) begin
            cal_unit = CAL_FLOOR;
        end else if (r_tick > TICK_W'(UNIT_MAX)) begin
            cal_unit = UNIT_MAX;
        end else begin
            cal_unit = r_tick[UNIT_W-1:0];
        end
    end

    assign dash = !calibrating && (r_tick >= TICK_W'(dash_lim));

    always_comb begin
        n_key_was_down = r_key_was_down;
        n_started      = r_started;
        n_pattern      = r_pattern;
        n_count        = r_count;
        n_ovf          = r_ovf;
        n_learned      = r_learned;
        tick_base      = r_tick;
        o_result.valid = 1'b0;
        o_result.res   = '0;

        priority if (press) begin
            n_started      = 1'b1;
            n_key_was_down = 1'b1;
            tick_base      = '0;
        end else if (release_key) begin
            if (calibrating) begin
                n_learned = cal_unit;
            end
            if (r_count < PATTERN_SLOTS) begin
                n_pattern[r_count] = dash;
            end else begin
                n_ovf = 1'b1;
            end
            if (r_count < COUNT_MAX) begin
                n_count = r_count + COUNT_W'(1);
            end
            o_result.valid                = 1'b1;
            o_result.res.result_kind      = KIND_ELEMENT;
            o_result.res.element_is_dash  = dash;
            o_result.res.pattern_overflow = n_ovf;
            tick_base      = '0;
            n_key_was_down = 1'b0;
        end else if (timeout) begin
            o_result.valid                = 1'b1;
            o_result.res.result_kind      = KIND_LETTER;
            o_result.res.letter_code      = {r_count, r_pattern};
            o_result.res.pattern_overflow = r_ovf;
            n_pattern = '0;
            n_count   = '0;
            n_ovf     = 1'b0;
            tick_base = '0;
        end else begin
        end

        if (i_beat.clear_entry) begin
            n_pattern = '0;
            n_count   = '0;
            n_ovf     = 1'b0;
        end

        n_tick = tick_base;
        if (n_started && tick_base != TICK_MAX) begin
            n_tick = tick_base + TICK_W'(1);
        end

        // only a beat that actually fires may produce a result
        o_result.valid = o_result.valid && i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_was_down <= 1'b0;
            r_started      <= 1'b0;
            r_tick         <= '0;
            r_pattern      <= '0;
            r_count        <= '0;
            r_ovf          <= 1'b0;
            r_learned      <= '0;
        end else if (i_fire) begin
            r_key_was_down <= n_key_was_down;
            r_started      <= n_started;
            r_tick         <= n_tick;
            r_pattern      <= n_pattern;
            r_count        <= n_count;
            r_ovf          <= n_ovf;
            r_learned      <= n_learned;
        end
    end

endmodule

// ----- hw/rtl/mktd_out_stage.sv -----
// ----------------------------------------------------------------------------
// mktd_out_stage
// Result register: holds one result beat until downstream takes it.
// ----------------------------------------------------------------------------
module mktd_out_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mktd_pkg::t_result_beat i_result,
    input  logic                   i_stall,
    output logic                   o_blocked,
    output logic                   o_valid,
    output mktd_pkg::t_result      o_res
);
    import mktd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_blocked = r_valid && i_stall;
    assign n_valid   = i_result.valid || o_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_res <= i_result.res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- hw/rtl/morse_key_timing_decoder.sv -----
// ----------------------------------------------------------------------------
// morse_key_timing_decoder
// Morse key sample decoder: element and letter results from key timing.
// ----------------------------------------------------------------------------
// One key sample is taken per timer tick. A sample passes an input register,
// is decoded combinationally against the mark/space timing state and, if it
// finishes an element or a letter, lands in the result register. Throughput
// is one sample per clock unless a held result stalls the input. A sample
// waits in the input register only while a finished result is held by
// downstream stall. Configuration (dot_unit at index 0, auto_calibrate at
// index 1) should be written while no sample is in flight.
module morse_key_timing_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mktd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mktd_pkg::UNIT_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_key_down,
    input  logic                           i_clear_entry,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_result_kind,
    output logic                           o_element_is_dash,
    output logic [mktd_pkg::CODE_W-1:0]    o_letter_code,
    output logic                           o_pattern_overflow
);
    import mktd_pkg::*;

    t_in_beat     in_beat;
    t_in_beat     held_beat;
    logic         held_valid;
    logic         out_blocked;
    logic         fire;
    t_result_beat result;
    t_result      out_res;

    assign in_beat.key_down    = i_key_down;
    assign in_beat.clear_entry = i_clear_entry;
    assign fire                = held_valid && !out_blocked;

    mktd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_beat    (in_beat),
        .i_advance (fire),
        .o_valid   (held_valid),
        .o_beat    (held_beat)
    );

    mktd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_beat      (held_beat),
        .o_result    (result)
    );

    mktd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_result  (result),
        .i_stall   (i_out_stall),
        .o_blocked (out_blocked),
        .o_valid   (o_out_valid),
        .o_res     (out_res)
    );

    assign o_result_kind      = out_res.result_kind;
    assign o_element_is_dash  = out_res.element_is_dash;
    assign o_letter_code      = out_res.letter_code;
    assign o_pattern_overflow = out_res.pattern_overflow;

endmodule

// ----- hw/rtl/mktd_checker.sv -----
// ----------------------------------------------------------------------------
// mktd_checker
// Port-level checks for the morse key timing decoder, bound to the top.
// ----------------------------------------------------------------------------
module mktd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_result_kind,
    input logic                           o_element_is_dash,
    input logic [mktd_pkg::CODE_W-1:0]    o_letter_code,
    input logic                           o_pattern_overflow
);
    import mktd_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_element_is_dash) && $stable(o_letter_code)
            && $stable(o_pattern_overflow))
        else $error("result beat changed while stalled");

    // a letter never carries a dash flag and always holds at least one element
    a_letter_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_LETTER) |->
            !o_element_is_dash && (o_letter_code[CODE_W-1:PATTERN_BITS] != '0))
        else $error("malformed letter result");

    // an element carries no letter code
    a_element_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_ELEMENT) |-> o_letter_code == '0)
        else $error("element result with letter code");

    // the input only backs up behind a result beat that downstream holds off
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no held result");

    // reset clears the result valid flag, so nothing shows right after it
    a_no_early_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind morse_key_timing_decoder mktd_checker u_mktd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_result_kind      (o_result_kind),
    .o_element_is_dash  (o_element_is_dash),
    .o_letter_code      (o_letter_code),
    .o_pattern_overflow (o_pattern_overflow)
);
